FILE: design/rlps_pkg.sv
// rlps_pkg: shared types and defaults for the ready list priority select block
// operation and status codes, controller state type, controller/datapath structs
// no dependencies
package rlps_pkg;

    localparam int DEF_LIST_DEPTH = 16;
    localparam int DEF_ID_BITS    = 8;
    localparam int DEF_PRIO_BITS  = 8;

    typedef enum logic [1:0] {
        KIND_INS_FRONT = 2'd0,
        KIND_APPEND    = 2'd1,
        KIND_REMOVE    = 2'd2,
        KIND_SELECT    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_op;
    } t_dp_stat;

endpackage

FILE: design/ready_list_priority_select.sv
// ready_list_priority_select: top level of the ordered ready list with priority select
// depends on rlps_pkg, rlps_ctrl and rlps_dp
//
//  channel   handshake            payload
//  --------  -------------------  -------------------------------------------------
//  op in     start / busy         i_kind, i_process_id, i_priority_req
//  result    o_done (one cycle)   o_status, o_selected_id, o_selected_priority,
//                                 o_entry_count
//
// insert and append go from idle straight to commit, remove and select pass through evaluate:
// the evaluate state registers the per-cell id match vector and the priority compare tree
// result is shown for one cycle on o_done, during which busy is already low,
// so a new op may be transferred in that same cycle
// reset is synchronous, active low, and empties the list; cell contents are not cleared
// the receiver cannot stall, every result must be taken when o_done is high
module ready_list_priority_select #(
    parameter int LIST_DEPTH = rlps_pkg::DEF_LIST_DEPTH,
    parameter int ID_BITS    = rlps_pkg::DEF_ID_BITS,
    parameter int PRIO_BITS  = rlps_pkg::DEF_PRIO_BITS,
    localparam int CW        = $clog2(LIST_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_kind,
    input  logic [ID_BITS-1:0]    i_process_id,
    input  logic [PRIO_BITS-1:0]  i_priority_req,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [ID_BITS-1:0]    o_selected_id,
    output logic [PRIO_BITS-1:0]  o_selected_priority,
    output logic [CW-1:0]         o_entry_count
);

    // command and status between the sequencer and the datapath
    rlps_pkg::t_dp_cmd  dp_cmd;
    rlps_pkg::t_dp_stat dp_stat;

    // sequencer: idle, optional evaluate state for scans, commit
    rlps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy)
    );

    // list cells, match vector, compare tree, result registers
    rlps_dp #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BITS    (ID_BITS),
        .PRIO_BITS  (PRIO_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_kind              (i_kind),
        .i_process_id        (i_process_id),
        .i_priority_req      (i_priority_req),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_selected_id       (o_selected_id),
        .o_selected_priority (o_selected_priority),
        .o_entry_count       (o_entry_count)
    );

`ifndef SYNTHESIS
    // the list never holds more entries than it has cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= CW'(LIST_DEPTH))
        else $error("entry count above list depth");

    // a result is only shown once the sequencer is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // a transfer always starts work
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    // one strobe per op
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held two cycles");

    // a dropped insert means the list is full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == rlps_pkg::ST_FULL)) |-> (o_entry_count == CW'(LIST_DEPTH)))
        else $error("full status with free cells");
`endif

endmodule

FILE: design/rlps_ctrl.sv
// rlps_ctrl: operation sequencer for the ready list
// depends on rlps_pkg (state type, command and status structs)
module rlps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  rlps_pkg::t_dp_stat i_stat,
    output rlps_pkg::t_dp_cmd  o_cmd,
    output logic               busy
);

    rlps_pkg::t_state r_state;
    rlps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlps_pkg::S_IDLE: begin
                if (start) begin
                    n_state = i_stat.scan_op ? rlps_pkg::S_EVAL : rlps_pkg::S_COMMIT;
                end
            end
            rlps_pkg::S_EVAL: begin
                n_state = rlps_pkg::S_COMMIT;
            end
            rlps_pkg::S_COMMIT: begin
                n_state = rlps_pkg::S_IDLE;
            end
            default: begin
                n_state = rlps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            rlps_pkg::S_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            rlps_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            rlps_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: design/rlps_dp.sv
// rlps_dp: list cells, id match vector, priority compare tree and result registers
// depends on rlps_pkg (codes, command and status structs)
module rlps_dp #(
    parameter int LIST_DEPTH = rlps_pkg::DEF_LIST_DEPTH,
    parameter int ID_BITS    = rlps_pkg::DEF_ID_BITS,
    parameter int PRIO_BITS  = rlps_pkg::DEF_PRIO_BITS,
    localparam int CW        = $clog2(LIST_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rlps_pkg::t_dp_cmd     i_cmd,
    output rlps_pkg::t_dp_stat    o_stat,
    input  logic [1:0]            i_kind,
    input  logic [ID_BITS-1:0]    i_process_id,
    input  logic [PRIO_BITS-1:0]  i_priority_req,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [ID_BITS-1:0]    o_selected_id,
    output logic [PRIO_BITS-1:0]  o_selected_priority,
    output logic [CW-1:0]         o_entry_count
);

    localparam int LW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int NL = 1 << LW;
    localparam int NN = 2 * NL - 1;

    rlps_pkg::t_kind        kind_in;
    rlps_pkg::t_kind        r_kind;
    logic [ID_BITS-1:0]     r_pid;
    logic [PRIO_BITS-1:0]   r_pri;

    logic [ID_BITS-1:0]     r_ids   [LIST_DEPTH];
    logic [PRIO_BITS-1:0]   r_prios [LIST_DEPTH];
    logic [ID_BITS-1:0]     n_ids   [LIST_DEPTH];
    logic [PRIO_BITS-1:0]   n_prios [LIST_DEPTH];
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;

    logic [LIST_DEPTH-1:0]  match_now;
    logic [LIST_DEPTH-1:0]  r_match;
    logic [LIST_DEPTH-1:0]  first_hit;
    logic [LIST_DEPTH-1:0]  shift_mask;

    logic                   nd_v  [NN];
    logic [PRIO_BITS-1:0]   nd_p  [NN];
    logic [ID_BITS-1:0]     nd_id [NN];
    logic [ID_BITS-1:0]     r_best_id;
    logic [PRIO_BITS-1:0]   r_best_pri;

    rlps_pkg::t_status      n_status;
    logic [ID_BITS-1:0]     n_sel_id;
    logic [PRIO_BITS-1:0]   n_sel_pri;
    logic                   full;

    logic                   r_done;
    rlps_pkg::t_status      r_status;
    logic [ID_BITS-1:0]     r_sel_id;
    logic [PRIO_BITS-1:0]   r_sel_pri;

    assign kind_in        = rlps_pkg::t_kind'(i_kind);
    assign o_stat.scan_op = (kind_in == rlps_pkg::KIND_REMOVE) ||
                            (kind_in == rlps_pkg::KIND_SELECT);

    // per-cell id compare, live entries only
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            match_now[i] = (CW'(i) < r_count) && (r_ids[i] == r_pid);
        end
    end

    // lowest set match bit, then every cell from there upward shifts down
    assign first_hit  = r_match & (~r_match + LIST_DEPTH'(1));
    assign shift_mask = ~(first_hit - LIST_DEPTH'(1));

    // compare tree, heap order, ties keep the left (front) side
    for (genvar g = 0; g < NL; g++) begin : g_leaf
        if (g < LIST_DEPTH) begin : g_live
            assign nd_v[NL-1+g]  = CW'(g) < r_count;
            assign nd_p[NL-1+g]  = r_prios[g];
            assign nd_id[NL-1+g] = r_ids[g];
        end else begin : g_pad
            assign nd_v[NL-1+g]  = 1'b0;
            assign nd_p[NL-1+g]  = '0;
            assign nd_id[NL-1+g] = '0;
        end
    end

    for (genvar n = 0; n < NL - 1; n++) begin : g_node
        logic right_wins;
        assign right_wins = nd_v[2*n+2] && (nd_p[2*n+2] > nd_p[2*n+1]);
        assign nd_v[n]    = nd_v[2*n+1];
        assign nd_p[n]    = right_wins ? nd_p[2*n+2]  : nd_p[2*n+1];
        assign nd_id[n]   = right_wins ? nd_id[2*n+2] : nd_id[2*n+1];
    end

    assign full = (r_count == CW'(LIST_DEPTH));

    always_comb begin
        n_ids     = r_ids;
        n_prios   = r_prios;
        n_count   = r_count;
        n_status  = rlps_pkg::ST_OK;
        n_sel_id  = '0;
        n_sel_pri = '0;
        unique case (r_kind)
            rlps_pkg::KIND_INS_FRONT: begin
                if (full) begin
                    n_status = rlps_pkg::ST_FULL;
                end else begin
                    n_ids[0]   = r_pid;
                    n_prios[0] = r_pri;
                    for (int i = 1; i < LIST_DEPTH; i++) begin
                        n_ids[i]   = r_ids[i-1];
                        n_prios[i] = r_prios[i-1];
                    end
                    n_count = r_count + CW'(1);
                end
            end
            rlps_pkg::KIND_APPEND: begin
                if (full) begin
                    n_status = rlps_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < LIST_DEPTH; i++) begin
                        if (CW'(i) == r_count) begin
                            n_ids[i]   = r_pid;
                            n_prios[i] = r_pri;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            rlps_pkg::KIND_REMOVE: begin
                if (|r_match) begin
                    for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                        if (shift_mask[i]) begin
                            n_ids[i]   = r_ids[i+1];
                            n_prios[i] = r_prios[i+1];
                        end
                    end
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = rlps_pkg::ST_NOT_FOUND;
                end
            end
            rlps_pkg::KIND_SELECT: begin
                if (r_count == '0) begin
                    n_status = rlps_pkg::ST_EMPTY;
                end else begin
                    n_sel_id  = r_best_id;
                    n_sel_pri = r_best_pri;
                end
            end
            default: begin
                n_status = rlps_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= kind_in;
            r_pid  <= i_process_id;
            r_pri  <= i_priority_req;
        end
        if (i_cmd.eval) begin
            r_match    <= match_now;
            r_best_id  <= nd_id[0];
            r_best_pri <= nd_p[0];
        end
        if (i_cmd.commit) begin
            r_ids     <= n_ids;
            r_prios   <= n_prios;
            r_status  <= n_status;
            r_sel_id  <= n_sel_id;
            r_sel_pri <= n_sel_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_count <= n_count;
            end
        end
    end

    assign o_done              = r_done;
    assign o_status            = r_status;
    assign o_selected_id       = r_sel_id;
    assign o_selected_priority = r_sel_pri;
    assign o_entry_count       = r_count;

endmodule
